[hdl/kkc_pkg.sv]
// Package for the k-clustering core: payload structs, configuration codes,
// field widths and the sequencer state type.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package kkc_pkg;

  localparam int NODE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int WOUT_W    = 24;
  localparam int RANK_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd1;

  localparam logic [CNT_W-1:0] NUM_POINTS_RESET   = 11'd1024;
  localparam logic [CNT_W-1:0] NUM_CLUSTERS_RESET = 11'd1;

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WOUT_W-1:0] edge_weight;
    logic              first_edge;
    logic              last_edge;
  } kkc_in_t;

  typedef struct packed {
    logic [WOUT_W-1:0] min_distance;
    logic              found;
    logic [CNT_W-1:0]  cluster_count;
  } kkc_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] num_points;
    logic [CNT_W-1:0] num_clusters;
  } kkc_cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_COMP,
    ST_FDONE,
    ST_MERGE,
    ST_RANK,
    ST_DONE
  } kkc_state_t;

endpackage

[hdl/kkc_uf_engine.sv]
// Union-find engine: parent/rank memory, root walker with path compression,
// union by rank, component count and smallest crossing weight.
// Depends on kkc_pkg.
`timescale 1ns / 1ps

module kkc_uf_engine import kkc_pkg::*; #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  kkc_cfg_t cfg,
  input  logic     item_valid,
  output logic     item_ready,
  input  kkc_in_t  item,
  output logic     res_valid,
  input  logic     res_ready,
  output kkc_out_t res
);

  localparam int AW        = $clog2(MAX_NODES);
  localparam int MW        = RANK_W + AW;
  localparam int WKB       = (WEIGHT_BITS < WOUT_W) ? WEIGHT_BITS : WOUT_W;
  localparam int MAXN_CLIP = (MAX_NODES < 2047) ? MAX_NODES : 2047;
  localparam int CNT_INIT  = (MAX_NODES < 1024) ? MAX_NODES : 1024;

  localparam logic [CNT_W-1:0] MAXN_C   = CNT_W'(MAXN_CLIP);
  localparam logic [CNT_W-1:0] CNT_RST  = CNT_W'(CNT_INIT);
  localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_NODES - 1);

  kkc_state_t state_r, state_nxt;

  // Memory word is {rank, parent}.
  logic [MW-1:0] uf_mem_r [0:MAX_NODES-1];
  logic [MW-1:0] rd_word_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [AW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;

  logic [AW-1:0]    clr_cnt_r;
  logic             pending_r;
  logic [CNT_W-1:0] count_r;
  logic [WKB-1:0]   best_r;
  logic             found_r;

  logic [NODE_W-1:0] a_r, b_r;
  logic [WKB-1:0]    w_r;
  logic              last_r;

  logic [AW-1:0]     cur_r, start_r, root_r, ra_r;
  logic [RANK_W-1:0] root_rank_r, rank_a_r;
  logic              sel_r, at_start_r;

  logic [16:0]      a_ext, b_ext;
  logic [AW-1:0]    addr_a, addr_b;
  logic [CNT_W-1:0] eff_n;
  logic             in_range;
  logic             merge_go;
  logic             a_over_b;
  logic             rank_bump;

  // Shared equality comparator, operands selected by state.
  logic [AW-1:0] cmp_x, cmp_y;
  logic          eq;

  assign rd_parent = rd_word_r[AW-1:0];
  assign rd_rank   = rd_word_r[AW +: RANK_W];

  assign a_ext  = 17'(a_r);
  assign b_ext  = 17'(b_r);
  assign addr_a = a_ext[AW-1:0];
  assign addr_b = b_ext[AW-1:0];

  assign eff_n     = (cfg.num_points > MAXN_C) ? MAXN_C : cfg.num_points;
  assign in_range  = (CNT_W'(a_r) < eff_n) && (CNT_W'(b_r) < eff_n);
  assign merge_go  = count_r > cfg.num_clusters;
  assign a_over_b  = rank_a_r > root_rank_r;
  assign rank_bump = (rank_a_r == root_rank_r) && (root_rank_r < RANK_MAX);

  always_comb begin
    unique case (state_r)
      ST_COMP: begin
        cmp_x = rd_parent;
        cmp_y = root_r;
      end
      ST_MERGE: begin
        cmp_x = ra_r;
        cmp_y = root_r;
      end
      default: begin
        cmp_x = cur_r;
        cmp_y = rd_parent;
      end
    endcase
  end

  assign eq = (cmp_x == cmp_y);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      uf_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= uf_mem_r[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = pending_r ? ST_CHECK : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = item.first_edge ? ST_CLEAR : ST_CHECK;
        end
      end
      ST_CHECK: state_nxt = in_range ? ST_WALK : ST_DONE;
      ST_WALK: begin
        if (eq) begin
          state_nxt = at_start_r ? ST_FDONE : ST_COMP;
        end
      end
      ST_COMP: begin
        if (eq) begin
          state_nxt = ST_FDONE;
        end
      end
      ST_FDONE: state_nxt = sel_r ? ST_MERGE : ST_WALK;
      ST_MERGE: begin
        if (!eq && merge_go && !a_over_b && rank_bump) begin
          state_nxt = ST_RANK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RANK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!last_r || res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: memory port controls and handshakes.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = cur_r;
    mem_wdata  = {rd_rank, root_r};
    mem_raddr  = rd_parent;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = {{RANK_W{1'b0}}, clr_cnt_r};
      end
      ST_IDLE: item_ready = 1'b1;
      ST_CHECK: mem_raddr = addr_a;
      ST_WALK: begin
        if (eq) begin
          mem_raddr = start_r;
        end
      end
      ST_COMP: begin
        mem_we = 1'b1;
      end
      ST_FDONE: mem_raddr = addr_b;
      ST_MERGE: begin
        if (!eq && merge_go) begin
          mem_we = 1'b1;
          if (a_over_b) begin
            mem_waddr = root_r;
            mem_wdata = {root_rank_r, ra_r};
          end else begin
            mem_waddr = ra_r;
            mem_wdata = {rank_a_r, root_r};
          end
        end
      end
      ST_RANK: begin
        mem_we    = 1'b1;
        mem_waddr = root_r;
        mem_wdata = {root_rank_r + RANK_W'(1), root_r};
      end
      ST_DONE: res_valid = last_r && res_ready;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pending_r <= 1'b0;
      count_r   <= CNT_RST;
      best_r    <= '1;
      found_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= (clr_cnt_r == CLR_LAST) ? '0 : clr_cnt_r + AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          pending_r <= 1'b0;
        end
      end
      if (state_r == ST_IDLE && item_valid && item.first_edge) begin
        pending_r <= 1'b1;
        count_r   <= eff_n;
        best_r    <= '1;
        found_r   <= 1'b0;
      end
      if (state_r == ST_MERGE && !eq) begin
        if (merge_go) begin
          count_r <= count_r - CNT_W'(1);
        end else if (!found_r || w_r < best_r) begin
          best_r  <= w_r;
          found_r <= 1'b1;
        end
      end
    end
  end

  // Walker and item registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          a_r    <= item.node_a;
          b_r    <= item.node_b;
          w_r    <= item.edge_weight[WKB-1:0];
          last_r <= item.last_edge;
        end
      end
      ST_CHECK: begin
        cur_r      <= addr_a;
        start_r    <= addr_a;
        at_start_r <= 1'b1;
        sel_r      <= 1'b0;
      end
      ST_WALK: begin
        if (eq) begin
          root_r      <= cur_r;
          root_rank_r <= rd_rank;
          cur_r       <= start_r;
        end else begin
          cur_r      <= rd_parent;
          at_start_r <= 1'b0;
        end
      end
      ST_COMP: cur_r <= rd_parent;
      ST_FDONE: begin
        if (!sel_r) begin
          ra_r       <= root_r;
          rank_a_r   <= root_rank_r;
          cur_r      <= addr_b;
          start_r    <= addr_b;
          at_start_r <= 1'b1;
          sel_r      <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.min_distance  = WOUT_W'(best_r);
  assign res.found         = found_r;
  assign res.cluster_count = count_r;

endmodule

[hdl/kruskal_k_clustering_core.sv]
// Top level of the k-clustering core: configuration registers, output
// register and the union-find engine.
// Depends on kkc_pkg and kkc_uf_engine.
//
//   Channel  Ports                          Moves
//   input    in_valid/in_ready/in_data      one edge per transaction
//   output   out_valid/out_ready/out_data   one result after a last edge
//   config   cfg_valid/cfg_ready/cfg_index  at most one register write per transaction
//            cfg_wdata
//
// Edges are handled one at a time: each endpoint is walked to its root and its
// path compressed, then the roots are merged if they differ and more than
// num_clusters components remain; a merge of two equal ranks adds a rank update,
// and an edge with an endpoint out of range skips the walks. Each walk step uses
// the single memory read port. After reset, and on every edge with first_edge set,
// the store is swept over all MAX_NODES entries while no edge is taken. A waiting
// result stalls the block only when the next last edge is ready to report.
`timescale 1ns / 1ps

module kruskal_k_clustering_core import kkc_pkg::*; #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kkc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kkc_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  kkc_cfg_t cfg_r;
  logic     out_valid_r;
  kkc_out_t out_data_r;
  logic     res_valid;
  logic     res_ready;
  kkc_out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_points   <= NUM_POINTS_RESET;
      cfg_r.num_clusters <= NUM_CLUSTERS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_POINTS:   cfg_r.num_points   <= cfg_wdata;
        CFG_NUM_CLUSTERS: cfg_r.num_clusters <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The result register frees as soon as its transaction completes.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kkc_uf_engine #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
